>>> hw/rtl/kpc_pkg.sv
// Shared types, constants and helpers for the key press classifier.
`timescale 1ns / 1ps
package kpc_pkg;

    localparam int KEYS_DEF   = 8;
    localparam int GROUPS_DEF = 2;
    localparam int NSETUP     = 2;
    localparam int MAX_EV     = 10;
    localparam int EV_CNT_W   = 4;
    localparam int CFG_W      = 38;
    localparam int CFG_IDX_W  = 3;
    localparam int MEMBERS    = 8;

    localparam logic [1:0] LV_OFF = 2'd0;
    localparam logic [1:0] LV_ON  = 2'd1;
    localparam logic [1:0] LV_UNK = 2'd3;

    localparam logic [7:0]  CI_RST    = 8'd10;
    localparam logic [15:0] SHORT_RST = 16'd50;
    localparam logic [15:0] LONG_RST  = 16'd1000;
    localparam logic [15:0] AUTO_RST  = 16'd500;

    typedef enum logic [1:0] {
        EV_SHORT = 2'd0,
        EV_LONG  = 2'd1,
        EV_AUTO  = 2'd2,
        EV_GROUP = 2'd3
    } t_evt_type;

    typedef enum logic [2:0] {
        REG_KEY_EN = 3'd0,
        REG_MODE   = 3'd1,
        REG_CI     = 3'd2,
        REG_SHORT  = 3'd3,
        REG_LONG   = 3'd4,
        REG_AUTO   = 3'd5,
        REG_GRP0   = 3'd6,
        REG_GRP1   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_KEY  = 2'd1,
        S_GRP  = 2'd2,
        S_OUT  = 2'd3
    } t_state;

    typedef struct packed {
        logic       vld;
        logic [3:0] key;
        logic [1:0] grp;
        t_evt_type  typ;
    } t_evt;

    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

    function automatic logic f_grp_active(input logic [CFG_W-1:0] s, input int keys);
        logic       ok;
        logic [3:0] n;
        ok = s[37];
        n  = s[35:32];
        if (n < 4'd2 || n > 4'd8 || 32'(n) > keys) ok = 1'b0;
        for (int a = 0; a < MEMBERS; a++) begin
            if (a < int'(n)) begin
                if (32'(s[4*a +: 4]) >= keys) ok = 1'b0;
                for (int b = a + 1; b < MEMBERS; b++) begin
                    if (b < int'(n) && s[4*a +: 4] == s[4*b +: 4]) ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

>>> hw/rtl/kpc_key_unit.sv
// Per-key debounce state and the shared key sample/classify step.
`timescale 1ns / 1ps
module kpc_key_unit #(
    parameter int KEYS   = kpc_pkg::KEYS_DEF,
    parameter int GROUPS = kpc_pkg::GROUPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [$clog2(KEYS)-1:0]   i_idx,
    input  logic                      i_raw,
    input  logic                      i_en,
    input  logic                      i_auto,
    input  logic                      i_member,
    input  logic [7:0]                i_ci,
    input  logic [15:0]               i_short,
    input  logic [15:0]               i_long,
    input  logic [15:0]               i_auto_time,
    output kpc_pkg::t_evt             o_evt,
    output logic [KEYS-1:0]           o_on
);
    import kpc_pkg::*;

    logic [7:0]  r_cnt  [KEYS];
    logic [1:0]  r_lvl  [KEYS];
    logic [1:0]  r_prev [KEYS];
    logic [15:0] r_held [KEYS];

    logic [7:0]  n_cnt;
    logic [1:0]  n_lvl;
    logic [15:0] n_held;
    logic [7:0]  w_cnt1;
    logic [16:0] w_sum;
    logic [15:0] w_h;
    logic [1:0]  w_prev;
    logic [15:0] w_held;

    always_comb begin
        w_prev = r_prev[i_idx];
        w_held = r_held[i_idx];
        w_cnt1 = r_cnt[i_idx] + 8'd1;
        w_sum  = {1'b0, w_held} + {9'd0, i_ci};
        w_h    = w_sum[16] ? 16'hFFFF : w_sum[15:0];
        n_cnt  = r_cnt[i_idx];
        n_lvl  = r_lvl[i_idx];
        n_held = w_held;
        o_evt  = '{vld: 1'b0, key: 4'(i_idx), grp: 2'(GROUPS), typ: EV_SHORT};
        if (i_en) begin
            if (w_cnt1 < i_ci) begin
                n_cnt = w_cnt1;
            end else begin
                n_cnt = 8'd0;
                if (!i_raw) begin
                    n_lvl = LV_OFF;
                end else if (i_member) begin
                    n_lvl = LV_ON;
                end else begin
                    if (!i_auto && w_prev == LV_OFF) n_lvl = LV_ON;
                    else if (i_auto && w_held == 16'd0) n_lvl = LV_ON;
                    n_held = w_h;
                    if (i_auto && w_h >= i_auto_time) n_lvl = LV_OFF;
                end
            end
        end
        if (w_prev == LV_ON && n_lvl == LV_OFF && !i_member) begin
            if (!i_auto) begin
                if (n_held != 16'd0 && n_held < i_long && n_held >= i_short) begin
                    o_evt.vld = 1'b1;
                    o_evt.typ = EV_SHORT;
                end else if (n_held != 16'd0 && n_held >= i_long) begin
                    o_evt.vld = 1'b1;
                    o_evt.typ = EV_LONG;
                end
            end else if (n_held != 16'd0) begin
                o_evt.vld = 1'b1;
                o_evt.typ = EV_AUTO;
            end
            n_held = 16'd0;
        end
        o_evt.vld = o_evt.vld & i_step;
    end

    always_comb begin
        for (int k = 0; k < KEYS; k++) o_on[k] = (r_lvl[k] == LV_ON);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEYS; k++) begin
                r_cnt[k]  <= 8'd0;
                r_held[k] <= 16'd0;
                r_lvl[k]  <= LV_UNK;
                r_prev[k] <= LV_UNK;
            end
        end else if (i_step) begin
            r_cnt[i_idx]  <= n_cnt;
            r_held[i_idx] <= n_held;
            r_lvl[i_idx]  <= n_lvl;
            r_prev[i_idx] <= n_lvl;
        end
    end

endmodule

>>> hw/rtl/kpc_grp_unit.sv
// Combination setups, member mask and the shared group check step.
`timescale 1ns / 1ps
module kpc_grp_unit #(
    parameter int KEYS   = kpc_pkg::KEYS_DEF,
    parameter int GROUPS = kpc_pkg::GROUPS_DEF,
    localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kpc_pkg::t_cfg_wr  i_cfg,
    input  logic              i_step,
    input  logic [GW-1:0]     i_idx,
    input  logic [KEYS-1:0]   i_on,
    output kpc_pkg::t_evt     o_evt,
    output logic [KEYS-1:0]   o_members
);
    import kpc_pkg::*;

    logic [CFG_W-1:0] r_setup [GROUPS];
    logic [7:0]       r_pat   [GROUPS];
    logic [1:0]       r_lvl   [GROUPS];
    logic [1:0]       r_prev  [GROUPS];

    logic [GROUPS-1:0] w_act;
    logic [CFG_W-1:0]  w_s;
    logic [3:0]        w_n;
    logic [7:0]        w_mo;
    logic [7:0]        w_full;
    logic [3:0]        w_top;
    logic              w_clr;
    logic [7:0]        n_pat;
    logic [1:0]        n_lvl;

    always_comb begin
        o_members = '0;
        for (int g = 0; g < GROUPS; g++) begin
            w_act[g] = f_grp_active(r_setup[g], KEYS);
            for (int m = 0; m < MEMBERS; m++) begin
                for (int k = 0; k < KEYS; k++) begin
                    if (w_act[g] && m < int'(r_setup[g][35:32]) &&
                        32'(r_setup[g][4*m +: 4]) == k) o_members[k] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_s   = r_setup[i_idx];
        w_n   = w_s[35:32];
        n_pat = r_pat[i_idx];
        n_lvl = r_lvl[i_idx];
        w_top = 4'd0;
        w_clr = 1'b0;
        for (int i = 0; i < MEMBERS; i++) begin
            w_mo[i]   = 1'b0;
            w_full[i] = (i < int'(w_n));
            for (int k = 0; k < KEYS; k++) begin
                if (32'(w_s[4*i +: 4]) == k && i_on[k]) w_mo[i] = 1'b1;
            end
            if (r_pat[i_idx][i]) w_top = 4'(i + 1);
        end
        if (w_act[i_idx]) begin
            if (!w_s[36]) begin
                for (int i = 0; i < MEMBERS; i++) begin
                    if (i < int'(w_n)) n_pat[i] = w_mo[i];
                end
                n_lvl = (n_pat == w_full) ? LV_ON : LV_OFF;
            end else if (w_top <= w_n) begin
                for (int i = 0; i < MEMBERS; i++) begin
                    if (i < int'(w_n) && i <= int'(w_top)) n_pat[i] = w_mo[i];
                    if (i < int'(w_n) && i > int'(w_top) && w_mo[i]) w_clr = 1'b1;
                end
                if (w_clr) n_pat = 8'd0;
                n_lvl = (n_pat == w_full) ? LV_ON : LV_OFF;
            end
        end
        o_evt = '{vld: 1'b0, key: 4'(KEYS), grp: 2'(i_idx), typ: EV_GROUP};
        if (r_prev[i_idx] == LV_OFF && n_lvl == LV_ON) begin
            o_evt.vld = i_step;
            n_pat     = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < GROUPS; g++) begin
                r_setup[g] <= '0;
                r_pat[g]   <= 8'd0;
                r_lvl[g]   <= LV_UNK;
                r_prev[g]  <= LV_UNK;
            end
        end else begin
            if (i_step) begin
                r_pat[i_idx]  <= n_pat;
                r_lvl[i_idx]  <= n_lvl;
                r_prev[i_idx] <= n_lvl;
            end
            for (int g = 0; g < GROUPS; g++) begin
                if (g < NSETUP && i_cfg.en &&
                    i_cfg.idx == CFG_IDX_W'(int'(REG_GRP0) + g)) begin
                    r_setup[g] <= i_cfg.data;
                    r_pat[g]   <= 8'd0;
                    if (!f_grp_active(i_cfg.data, KEYS)) begin
                        r_lvl[g]  <= LV_UNK;
                        r_prev[g] <= LV_UNK;
                    end
                end
            end
        end
    end

endmodule

>>> hw/rtl/key_press_classifier.sv
// One tick walks KEYS key steps then GROUPS group steps, one per cycle.
// Events then leave one per transfer from a ten-entry buffer, last one flagged.
// A new tick is accepted only once the last one's steps are done and its events have left;
// output stalls hold it back. The single key step unit and group step unit serve all steps.
// Synchronous active-low reset: levels unknown, counters and held times zero,
// registers to their reset values, buffer empty.
`timescale 1ns / 1ps
module key_press_classifier #(
    parameter int KEYS   = kpc_pkg::KEYS_DEF,
    parameter int GROUPS = kpc_pkg::GROUPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // raw_keys
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // event_key, event_group, event_type
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_we,
    input  logic [kpc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kpc_pkg::CFG_W-1:0]       i_cfg_data
);
    import kpc_pkg::*;

    localparam int KW = $clog2(KEYS);
    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    logic [7:0]  r_en, r_mode, r_ci;
    logic [15:0] r_short, r_long, r_auto;

    t_state              r_state, n_state;
    logic [KW-1:0]       r_kidx, n_kidx;
    logic [GW-1:0]       r_gidx, n_gidx;
    logic [7:0]          r_raw, n_raw;
    logic [EV_CNT_W-1:0] r_nev, n_nev;
    logic [EV_CNT_W-1:0] r_rd, n_rd;
    logic [7:0]          r_buf [MAX_EV];

    t_cfg_wr         w_cfg;
    t_evt            w_kevt, w_gevt, w_evt;
    logic [KEYS-1:0] w_on, w_members, w_raw, w_en, w_mode;
    logic            w_wr;

    assign w_cfg  = '{en: i_cfg_we, idx: i_cfg_idx, data: i_cfg_data};
    assign w_raw  = KEYS'(r_raw);
    assign w_en   = KEYS'(r_en);
    assign w_mode = KEYS'(r_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= 8'd0;
            r_mode  <= 8'd0;
            r_ci    <= CI_RST;
            r_short <= SHORT_RST;
            r_long  <= LONG_RST;
            r_auto  <= AUTO_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_KEY_EN: r_en    <= i_cfg_data[7:0];
                REG_MODE:   r_mode  <= i_cfg_data[7:0];
                REG_CI:     r_ci    <= i_cfg_data[7:0];
                REG_SHORT:  r_short <= i_cfg_data[15:0];
                REG_LONG:   r_long  <= i_cfg_data[15:0];
                REG_AUTO:   r_auto  <= i_cfg_data[15:0];
                REG_GRP0, REG_GRP1: ;
            endcase
        end
    end

    kpc_key_unit #(.KEYS(KEYS), .GROUPS(GROUPS)) u_key (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (r_state == S_KEY),
        .i_idx       (r_kidx),
        .i_raw       (w_raw[r_kidx]),
        .i_en        (w_en[r_kidx]),
        .i_auto      (w_mode[r_kidx]),
        .i_member    (w_members[r_kidx]),
        .i_ci        (r_ci),
        .i_short     (r_short),
        .i_long      (r_long),
        .i_auto_time (r_auto),
        .o_evt       (w_kevt),
        .o_on        (w_on)
    );

    kpc_grp_unit #(.KEYS(KEYS), .GROUPS(GROUPS)) u_grp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_step    (r_state == S_GRP),
        .i_idx     (r_gidx),
        .i_on      (w_on),
        .o_evt     (w_gevt),
        .o_members (w_members)
    );

    assign w_evt = (r_state == S_GRP) ? w_gevt : w_kevt;
    assign w_wr  = w_evt.vld && (r_nev < EV_CNT_W'(MAX_EV));

    always_comb begin
        n_state       = r_state;
        n_kidx        = r_kidx;
        n_gidx        = r_gidx;
        n_raw         = r_raw;
        n_nev         = r_nev;
        n_rd          = r_rd;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        m_axis_tdata  = r_buf[r_rd];
        m_axis_tlast  = (r_rd == r_nev - EV_CNT_W'(1));
        if (w_wr) n_nev = r_nev + EV_CNT_W'(1);
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_raw   = s_axis_tdata;
                    n_kidx  = '0;
                    n_gidx  = '0;
                    n_nev   = '0;
                    n_rd    = '0;
                    n_state = S_KEY;
                end
            end
            S_KEY: begin
                n_kidx = r_kidx + KW'(1);
                if (r_kidx == KW'(KEYS - 1)) n_state = S_GRP;
            end
            S_GRP: begin
                n_gidx = r_gidx + GW'(1);
                if (r_gidx == GW'(GROUPS - 1)) n_state = (n_nev != '0) ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_rd = r_rd + EV_CNT_W'(1);
                    if (m_axis_tlast) n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kidx  <= '0;
            r_gidx  <= '0;
            r_nev   <= '0;
            r_rd    <= '0;
        end else begin
            r_state <= n_state;
            r_kidx  <= n_kidx;
            r_gidx  <= n_gidx;
            r_nev   <= n_nev;
            r_rd    <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw <= n_raw;
        if (w_wr) r_buf[r_nev] <= {w_evt.typ, w_evt.grp, w_evt.key};
    end

endmodule
